// ===== hdl/mtpm_pkg.sv =====
package mtpm_pkg;

  localparam int NORMAL_DEPTH   = 256;
  localparam int REALTIME_DEPTH = 16;
  localparam int SIDE_DEPTH     = 256;

  localparam int N_IW = $clog2(NORMAL_DEPTH);
  localparam int N_CW = $clog2(NORMAL_DEPTH + 1);
  localparam int R_IW = $clog2(REALTIME_DEPTH);
  localparam int R_CW = $clog2(REALTIME_DEPTH + 1);
  localparam int S_IW = $clog2(SIDE_DEPTH);
  localparam int S_CW = $clog2(SIDE_DEPTH + 1);

  localparam int RAM_DEPTH = NORMAL_DEPTH + REALTIME_DEPTH + SIDE_DEPTH;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [RAM_AW-1:0] NORMAL_BASE   = RAM_AW'(0);
  localparam logic [RAM_AW-1:0] REALTIME_BASE = RAM_AW'(NORMAL_DEPTH);
  localparam logic [RAM_AW-1:0] SIDE_BASE     = RAM_AW'(NORMAL_DEPTH + REALTIME_DEPTH);

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] SONG_POS    = 8'hF2;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [3:0] KIND_PROG   = 4'hC;
  localparam logic [3:0] KIND_PRESS  = 4'hD;

  localparam logic [2:0] OWED_IDLE = 3'd0;
  localparam logic [2:0] OWED_ONE  = 3'd1;
  localparam logic [2:0] OWED_TWO  = 3'd2;
  localparam logic [2:0] OWED_OPEN = 3'd7;

  typedef enum logic [1:0] {
    ACT_PUSH_NORMAL,
    ACT_PUSH_REALTIME,
    ACT_PUSH_SIDE,
    ACT_PULL
  } action_t;

  typedef enum logic [1:0] {
    SRC_NORMAL,
    SRC_REALTIME,
    SRC_SIDE
  } source_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic    sent;
    source_t source;
    logic    ok;
    logic    normal_pop;
  } step_t;

  function automatic logic [2:0] track_byte(input logic [2:0] owed, input logic [7:0] b);
    logic [2:0] res;
    res = owed;
    if ((owed == OWED_ONE || owed == OWED_TWO) && !b[7]) begin
      res = owed - 3'd1;
    end else if (b < SYSEX_START) begin
      if (b[7:4] == KIND_PROG || b[7:4] == KIND_PRESS) begin
        res = OWED_ONE;
      end else if (b[7]) begin
        res = OWED_TWO;
      end
    end else begin
      case (b)
        SYSEX_START: res = OWED_OPEN;
        SYSEX_END:   res = OWED_IDLE;
        MTC_QFRAME:  res = OWED_ONE;
        SONG_SEL:    res = OWED_ONE;
        SONG_POS:    res = OWED_TWO;
        default:     res = owed;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== hdl/mtpm_ram.sv =====
module mtpm_ram #(
  parameter int DEPTH = 528,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mtpm_arb.sv =====
module mtpm_arb
  import mtpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  action_t    action,
  input  logic [7:0] data_byte,
  input  logic [2:0] owed_cur,
  output mem_req_t   mem_req,
  output step_t      step
);

  logic [N_IW-1:0] nhead_r, nhead_nxt;
  logic [N_CW-1:0] ncount_r, ncount_nxt;
  logic [R_IW-1:0] rhead_r, rhead_nxt;
  logic [R_CW-1:0] rcount_r, rcount_nxt;
  logic [S_IW-1:0] shead_r, shead_nxt;
  logic [S_CW-1:0] scount_r, scount_nxt;
  logic            attached_r, attached_nxt;

  logic [N_IW:0]   nsum;
  logic [R_IW:0]   rsum;
  logic [S_IW:0]   ssum;
  logic [N_IW-1:0] nwidx;
  logic [R_IW-1:0] rwidx;
  logic [S_IW-1:0] swidx;
  logic            nfull, rfull, sfull;

  assign nsum  = {1'b0, nhead_r} + (N_IW+1)'(ncount_r);
  assign rsum  = {1'b0, rhead_r} + (R_IW+1)'(rcount_r);
  assign ssum  = {1'b0, shead_r} + (S_IW+1)'(scount_r);
  assign nwidx = (nsum >= (N_IW+1)'(NORMAL_DEPTH)) ?
                 N_IW'(nsum - (N_IW+1)'(NORMAL_DEPTH)) : N_IW'(nsum);
  assign rwidx = (rsum >= (R_IW+1)'(REALTIME_DEPTH)) ?
                 R_IW'(rsum - (R_IW+1)'(REALTIME_DEPTH)) : R_IW'(rsum);
  assign swidx = (ssum >= (S_IW+1)'(SIDE_DEPTH)) ?
                 S_IW'(ssum - (S_IW+1)'(SIDE_DEPTH)) : S_IW'(ssum);
  assign nfull = (ncount_r == N_CW'(NORMAL_DEPTH));
  assign rfull = (rcount_r == R_CW'(REALTIME_DEPTH));
  assign sfull = (scount_r == S_CW'(SIDE_DEPTH));

  always_comb begin
    nhead_nxt    = nhead_r;
    ncount_nxt   = ncount_r;
    rhead_nxt    = rhead_r;
    rcount_nxt   = rcount_r;
    shead_nxt    = shead_r;
    scount_nxt   = scount_r;
    attached_nxt = attached_r;
    mem_req      = '0;
    mem_req.wdata = data_byte;
    step         = '0;
    step.source  = SRC_NORMAL;
    if (accept) begin
      unique case (action)
        ACT_PUSH_NORMAL: begin
          step.ok = !nfull;
          if (!nfull) begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = NORMAL_BASE + RAM_AW'(nwidx);
            ncount_nxt   = ncount_r + 1'b1;
          end
        end
        ACT_PUSH_REALTIME: begin
          step.ok = !rfull;
          if (!rfull) begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = REALTIME_BASE + RAM_AW'(rwidx);
            rcount_nxt   = rcount_r + 1'b1;
          end
        end
        ACT_PUSH_SIDE: begin
          attached_nxt = 1'b1;
          step.ok      = !sfull;
          if (!sfull) begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = SIDE_BASE + RAM_AW'(swidx);
            scount_nxt   = scount_r + 1'b1;
          end
        end
        ACT_PULL: begin
          if (rcount_r != '0) begin
            mem_req.en   = 1'b1;
            mem_req.addr = REALTIME_BASE + RAM_AW'(rhead_r);
            rcount_nxt   = rcount_r - 1'b1;
            rhead_nxt    = (rhead_r == R_IW'(REALTIME_DEPTH - 1)) ? '0 : rhead_r + 1'b1;
            step.sent    = 1'b1;
            step.source  = SRC_REALTIME;
          end else if (attached_r && owed_cur == OWED_IDLE && scount_r != '0) begin
            mem_req.en   = 1'b1;
            mem_req.addr = SIDE_BASE + RAM_AW'(shead_r);
            scount_nxt   = scount_r - 1'b1;
            shead_nxt    = (shead_r == S_IW'(SIDE_DEPTH - 1)) ? '0 : shead_r + 1'b1;
            step.sent    = 1'b1;
            step.source  = SRC_SIDE;
          end else begin
            if (attached_r && owed_cur == OWED_IDLE) begin
              attached_nxt = 1'b0;
            end
            if (ncount_r != '0) begin
              mem_req.en      = 1'b1;
              mem_req.addr    = NORMAL_BASE + RAM_AW'(nhead_r);
              ncount_nxt      = ncount_r - 1'b1;
              nhead_nxt       = (nhead_r == N_IW'(NORMAL_DEPTH - 1)) ? '0 : nhead_r + 1'b1;
              step.sent       = 1'b1;
              step.normal_pop = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nhead_r    <= '0;
      ncount_r   <= '0;
      rhead_r    <= '0;
      rcount_r   <= '0;
      shead_r    <= '0;
      scount_r   <= '0;
      attached_r <= 1'b0;
    end else begin
      nhead_r    <= nhead_nxt;
      ncount_r   <= ncount_nxt;
      rhead_r    <= rhead_nxt;
      rcount_r   <= rcount_nxt;
      shead_r    <= shead_nxt;
      scount_r   <= scount_nxt;
      attached_r <= attached_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ncount_r <= N_CW'(NORMAL_DEPTH) && rcount_r <= R_CW'(REALTIME_DEPTH) &&
    scount_r <= S_CW'(SIDE_DEPTH))
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && action == ACT_PULL && rcount_r != '0 |-> step.source == SRC_REALTIME)
    else $error("realtime word not served first");

  assert property (@(posedge clk) disable iff (!rst_n)
    step.source == SRC_SIDE |-> owed_cur == OWED_IDLE && attached_r)
    else $error("side word sent inside a message");

endmodule

// ===== hdl/midi_tx_priority_merge_core.sv =====
// Three-queue MIDI transmit merge. Push words (normal, realtime, side) and pull
// words all enter on one channel; each accepted word yields exactly one result
// word, in the cycle after acceptance, and a new word is taken every cycle while
// out_stall is low. All three queues share one single-port synchronous RAM, and
// each word makes at most one access to it, which is what sets the rate of one
// word per cycle. The queue contents need no clearing after reset; pointers,
// fill counts and the message tracker reset at once.
module midi_tx_priority_merge_core
  import mtpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic [1:0] out_out_source,
  output logic       out_push_ok,
  output logic       out_mid_message
);

  mem_req_t   mem_req;
  step_t      step;
  logic [7:0] rd_data;
  logic       accept;
  logic [2:0] owed_cur;

  logic       s2_valid_r, s2_valid_nxt;
  logic       s2_sent_r;
  source_t    s2_source_r;
  logic       s2_ok_r;
  logic       pending_r, pending_nxt;
  logic [2:0] owed_r;

  assign in_stall = s2_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // fold the last normal word into the tracker as soon as it leaves the RAM
  assign owed_cur = pending_r ? track_byte(owed_r, rd_data) : owed_r;

  mtpm_arb u_arb (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (action_t'(in_action)),
    .data_byte (in_data_byte),
    .owed_cur  (owed_cur),
    .mem_req   (mem_req),
    .step      (step)
  );

  mtpm_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rd_data)
  );

  assign s2_valid_nxt = accept || (s2_valid_r && out_stall);
  assign pending_nxt  = accept && step.normal_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      pending_r  <= 1'b0;
      owed_r     <= OWED_IDLE;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      pending_r  <= pending_nxt;
      owed_r     <= owed_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_sent_r   <= step.sent;
      s2_source_r <= step.source;
      s2_ok_r     <= step.ok;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_out_byte    = s2_sent_r ? rd_data : 8'h00;
  assign out_out_valid   = s2_sent_r;
  assign out_out_source  = s2_source_r;
  assign out_push_ok     = s2_ok_r;
  assign out_mid_message = (owed_cur != OWED_IDLE);

  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> s2_valid_r && s2_sent_r && s2_source_r == SRC_NORMAL)
    else $error("tracker update without a normal word in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && out_stall |=> $stable(out_out_byte) && $stable(out_mid_message))
    else $error("held result word changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_ok |-> !out_out_valid)
    else $error("push word reported a sent byte");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import mtpm_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       sent;
    source_t    src;
    logic       ok;
    logic       mid;
  } merge_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_action;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_out_byte;
  logic       out_out_valid;
  logic [1:0] out_out_source;
  logic       out_push_ok;
  logic       out_mid_message;

  logic [7:0] normal_bytes[$];
  logic [7:0] realtime_bytes[$];
  logic [7:0] side_bytes[$];
  logic [2:0] owed;
  logic       side_on;
  logic       last_ok;

  merge_result_t pending_outputs[$];
  merge_result_t exp_r;
  logic [7:0]    msg_bytes[$];

  bit gaps_on;
  int hold_left;
  int errors;
  int words_sent;
  int results_seen;
  int sent_by_src[3];
  int empty_pulls;
  int dropped;

  midi_tx_priority_merge_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_out_valid  (out_out_valid),
    .out_out_source (out_out_source),
    .out_push_ok    (out_push_ok),
    .out_mid_message(out_mid_message)
  );

  always #2 clk = ~clk;

  function automatic void advance_owed(input logic [7:0] b);
    if ((owed == OWED_ONE || owed == OWED_TWO) && !b[7]) begin
      owed = owed - 3'd1;
    end else begin
      case (b[7:4])
        4'h8, 4'h9, 4'hA, 4'hB, 4'hE: owed = OWED_TWO;
        KIND_PROG, KIND_PRESS: owed = OWED_ONE;
        4'hF: begin
          case (b)
            SYSEX_START:          owed = OWED_OPEN;
            SYSEX_END:            owed = OWED_IDLE;
            MTC_QFRAME, SONG_SEL: owed = OWED_ONE;
            SONG_POS:             owed = OWED_TWO;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  endfunction

  function automatic merge_result_t predict_merge(input action_t act, input logic [7:0] b);
    merge_result_t r;
    r.data = 8'h00;
    r.sent = 1'b0;
    r.src  = SRC_NORMAL;
    r.ok   = 1'b0;
    case (act)
      ACT_PUSH_NORMAL: begin
        if (normal_bytes.size() < NORMAL_DEPTH) begin
          normal_bytes.push_back(b);
          r.ok = 1'b1;
        end
      end
      ACT_PUSH_REALTIME: begin
        if (realtime_bytes.size() < REALTIME_DEPTH) begin
          realtime_bytes.push_back(b);
          r.ok = 1'b1;
        end
      end
      ACT_PUSH_SIDE: begin
        side_on = 1'b1;
        if (side_bytes.size() < SIDE_DEPTH) begin
          side_bytes.push_back(b);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (realtime_bytes.size() != 0) begin
          r.data = realtime_bytes.pop_front();
          r.sent = 1'b1;
          r.src  = SRC_REALTIME;
        end else begin
          if (side_on && owed == OWED_IDLE) begin
            if (side_bytes.size() != 0) begin
              r.data = side_bytes.pop_front();
              r.sent = 1'b1;
              r.src  = SRC_SIDE;
            end else begin
              side_on = 1'b0;
            end
          end
          if (!r.sent && normal_bytes.size() != 0) begin
            r.data = normal_bytes.pop_front();
            r.sent = 1'b1;
            advance_owed(r.data);
          end
        end
        if (r.sent) sent_by_src[r.src]++;
        else empty_pulls++;
      end
    endcase
    if (act != ACT_PULL && !r.ok) dropped++;
    last_ok = r.ok;
    r.mid = (owed != OWED_IDLE);
    return r;
  endfunction

  task automatic send_word(input action_t act, input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outputs.push_back(predict_merge(act, b));
    words_sent++;
  endtask

  function automatic void build_message();
    int         k;
    int         n;
    logic [7:0] st;
    k = $urandom_range(9);
    case (k)
      5: begin
        msg_bytes.push_back(SYSEX_START);
        n = $urandom_range(8);
        repeat (n) msg_bytes.push_back(8'($urandom_range(127)));
        msg_bytes.push_back(SYSEX_END);
      end
      6: begin
        n = $urandom_range(2);
        st = (n == 0) ? MTC_QFRAME : (n == 1) ? SONG_SEL : SONG_POS;
        msg_bytes.push_back(st);
        repeat ((st == SONG_POS) ? 2 : 1) msg_bytes.push_back(8'($urandom_range(127)));
      end
      7: begin
        st = 8'($urandom_range(8'hF4, 8'hFF));
        msg_bytes.push_back((st == SYSEX_END) ? 8'hF6 : st);
      end
      8: begin
        repeat (2) msg_bytes.push_back(8'($urandom_range(127)));
      end
      default: begin
        st = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
        n = (st[7:4] == KIND_PROG || st[7:4] == KIND_PRESS) ? 1 : 2;
        if (k == 9) n = n - 1;
        msg_bytes.push_back(st);
        repeat (n) msg_bytes.push_back(8'($urandom_range(127)));
      end
    endcase
  endfunction

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_word(ACT_PULL, 8'($urandom));
    end else if (r < 75) begin
      if (msg_bytes.size() == 0) build_message();
      send_word(ACT_PUSH_NORMAL, msg_bytes.pop_front());
    end else if (r < 85) begin
      send_word(ACT_PUSH_REALTIME,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'hF8, 8'hFF)));
    end else if (r < 95) begin
      send_word(ACT_PUSH_SIDE, 8'($urandom));
    end else begin
      send_word(ACT_PUSH_NORMAL, 8'($urandom));
    end
  endtask

  task automatic test_empty_pull();
    send_word(ACT_PULL, 8'hFF);
  endtask

  task automatic test_priority();
    send_word(ACT_PUSH_NORMAL, 8'h90);
    send_word(ACT_PUSH_NORMAL, 8'h00);
    send_word(ACT_PUSH_NORMAL, 8'h7F);
    send_word(ACT_PUSH_SIDE, 8'h55);
    send_word(ACT_PUSH_REALTIME, 8'hF8);
    repeat (5) send_word(ACT_PULL, 8'h00);
  endtask

  task automatic test_side_waits_for_boundary();
    send_word(ACT_PUSH_NORMAL, 8'hC3);
    send_word(ACT_PUSH_NORMAL, 8'h10);
    send_word(ACT_PULL, 8'h00);
    send_word(ACT_PUSH_SIDE, 8'h2A);
    send_word(ACT_PULL, 8'h00);
    send_word(ACT_PULL, 8'h00);
    send_word(ACT_PULL, 8'h00);
  endtask

  task automatic test_fill_drain();
    int drops[3];
    int q;
    drops = '{0, 0, 0};
    while (drops[0] < 2 || drops[1] < 2 || drops[2] < 2) begin
      q = $urandom_range(2);
      if (drops[q] < 2) begin
        send_word(action_t'(q), 8'($urandom));
        if (!last_ok) drops[q]++;
      end
    end
    while (normal_bytes.size() != 0 || realtime_bytes.size() != 0 || side_bytes.size() != 0) begin
      if (normal_bytes.size() == 0 && owed != OWED_IDLE) send_word(ACT_PUSH_NORMAL, SYSEX_END);
      else send_word(ACT_PULL, 8'($urandom));
    end
    send_word(ACT_PULL, 8'h00);
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) random_step();
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (60) random_step();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        exp_r = pending_outputs.pop_front();
        if (out_out_byte !== exp_r.data) begin
          $error("out_byte expected %0h actual %0h", exp_r.data, out_out_byte);
          errors++;
        end
        if (out_out_valid !== exp_r.sent) begin
          $error("out_valid expected %0b actual %0b", exp_r.sent, out_out_valid);
          errors++;
        end
        if (out_out_source !== exp_r.src) begin
          $error("out_source expected %0d actual %0d", exp_r.src, out_out_source);
          errors++;
        end
        if (out_push_ok !== exp_r.ok) begin
          $error("push_ok expected %0b actual %0b", exp_r.ok, out_push_ok);
          errors++;
        end
        if (out_mid_message !== exp_r.mid) begin
          $error("mid_message expected %0b actual %0b", exp_r.mid, out_mid_message);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_PULL;
    in_data_byte = 8'h00;
    out_stall    = 1'b0;
    owed         = OWED_IDLE;
    side_on      = 1'b0;
    last_ok      = 1'b0;
    gaps_on      = 1'b1;
    hold_left    = 0;
    errors       = 0;
    words_sent   = 0;
    results_seen = 0;
    sent_by_src  = '{0, 0, 0};
    empty_pulls  = 0;
    dropped      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pull();
    test_priority();
    test_side_waits_for_boundary();
    gaps_on = 1'b0;
    test_random_traffic(60);
    gaps_on = 1'b1;
    test_fill_drain();
    test_random_traffic(60);
    test_backpressure();
    test_random_traffic(40);

    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Sent %0d words, checked %0d results: %0d normal, %0d realtime, %0d side bytes,",
             words_sent, results_seen, sent_by_src[SRC_NORMAL], sent_by_src[SRC_REALTIME],
             sent_by_src[SRC_SIDE]);
    $display("%0d empty pulls, %0d pushes dropped on full queues, one long output hold-off",
             empty_pulls, dropped);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
